// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the distance matrix RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_CLK(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("%m: check failed");
`define ASSERT_NORST(lbl, prop) \
  lbl: assert property (@(posedge clk) (prop)) else $error("%m: check failed");
`else
`define ASSERT_CLK(lbl, prop)
`define ASSERT_NORST(lbl, prop)
`endif
`endif

// ----- rtl/core/dmat_pkg.sv -----
// Constants, payload types and state encoding of the distance matrix block.
package dmat_pkg;

  localparam int POINTS     = 64;
  localparam int COORD_BITS = 16;

  localparam int IDX_W      = 6;
  localparam int COL_W      = 6;
  localparam int IN_COORD_W = 16;
  localparam int DIST_W     = 25;
  localparam int PC_W       = 7;

  localparam int PT_AW      = (POINTS > 1) ? $clog2(POINTS) : 1;
  localparam int CNT_W      = $clog2(POINTS + 1);
  localparam int MAG_BITS   = COORD_BITS + 1;
  localparam int PROD_BITS  = 2 * MAG_BITS;
  localparam int FRAC_SHIFT = 16;
  localparam int RAD_W      = 2 * DIST_W;
  localparam int SAT_BIT    = RAD_W - FRAC_SHIFT;
  localparam int SQ_BITS    = (PROD_BITS + 1 > SAT_BIT + 1) ? PROD_BITS + 1 : SAT_BIT + 1;
  localparam int SQ_CNT_W   = $clog2(MAG_BITS + 1);
  localparam int RT_CNT_W   = $clog2(DIST_W + 1);
  localparam int PT_W       = 2 * COORD_BITS;

  localparam int APB_AW = 2;
  localparam int APB_DW = 32;

  localparam logic [APB_AW-1:0] REG_POINT_COUNT = '0;
  localparam logic [PC_W-1:0]   PC_RESET        = 7'd64;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_ROW  = 1'b1;

  typedef struct packed {
    logic                  op;
    logic [IDX_W-1:0]      index;
    logic [IN_COORD_W-1:0] x_coord;
    logic [IN_COORD_W-1:0] y_coord;
  } req_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic [COL_W-1:0]  column;
    logic              last;
    logic              row_error;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROWRD,
    ST_COLRD,
    ST_SQ,
    ST_ROOT
  } state_t;

endpackage

// ----- rtl/core/dmat_ram.sv -----
// Generic simple dual-port RAM with registered read.
module dmat_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/dmat_sq.sv -----
// Bit-serial squarer: one multiplier bit per cycle, shift-add.
module dmat_sq (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            load,
  input  logic [dmat_pkg::MAG_BITS-1:0]   operand,
  output logic                            done,
  output logic [dmat_pkg::PROD_BITS-1:0]  product
);

  logic [dmat_pkg::PROD_BITS-1:0] acc;
  logic [dmat_pkg::MAG_BITS-1:0]  mcand;
  logic [dmat_pkg::SQ_CNT_W-1:0]  cnt;
  logic                           run;
  logic [dmat_pkg::MAG_BITS:0]    upper_sum;
  logic [dmat_pkg::PROD_BITS:0]   acc_wide;

  always_comb begin
    upper_sum = {1'b0, acc[dmat_pkg::PROD_BITS-1:dmat_pkg::MAG_BITS]}
              + (acc[0] ? {1'b0, mcand} : '0);
    acc_wide  = {upper_sum, acc[dmat_pkg::MAG_BITS-1:0]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= run && (cnt == dmat_pkg::SQ_CNT_W'(1));
      if (load) begin
        run <= 1'b1;
      end else if (run && (cnt == dmat_pkg::SQ_CNT_W'(1))) begin
        run <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      acc   <= dmat_pkg::PROD_BITS'(operand);
      mcand <= operand;
      cnt   <= dmat_pkg::SQ_CNT_W'(dmat_pkg::MAG_BITS);
    end else if (run) begin
      acc <= acc_wide[dmat_pkg::PROD_BITS:1];
      cnt <= cnt - dmat_pkg::SQ_CNT_W'(1);
    end
  end

  assign product = acc;

endmodule

// ----- rtl/core/dmat_sqrt.sv -----
// Bit-serial square root of the sum as a Q.8 result, one root bit per cycle, saturating.
module dmat_sqrt (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          load,
  input  logic [dmat_pkg::SQ_BITS-1:0]  sum,
  output logic                          done,
  output logic [dmat_pkg::DIST_W-1:0]   root
);

  logic [dmat_pkg::RAD_W-1:0]    rad;
  logic [dmat_pkg::DIST_W+1:0]   rem;
  logic [dmat_pkg::RT_CNT_W-1:0] cnt;
  logic                          run;
  logic                          sat;
  logic [dmat_pkg::DIST_W+1:0]   rem_sh;
  logic [dmat_pkg::DIST_W+1:0]   trial;
  logic                          fit;

  always_comb begin
    sat    = |sum[dmat_pkg::SQ_BITS-1:dmat_pkg::SAT_BIT];
    rem_sh = {rem[dmat_pkg::DIST_W-1:0], rad[dmat_pkg::RAD_W-1 -: 2]};
    trial  = {root, 2'b01};
    fit    = (rem_sh >= trial);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= (load && sat) || (run && (cnt == dmat_pkg::RT_CNT_W'(1)));
      if (load) begin
        run <= !sat;
      end else if (run && (cnt == dmat_pkg::RT_CNT_W'(1))) begin
        run <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rad  <= {sum[dmat_pkg::SAT_BIT-1:0], dmat_pkg::FRAC_SHIFT'(0)};
      rem  <= '0;
      root <= sat ? '1 : '0;
      cnt  <= dmat_pkg::RT_CNT_W'(dmat_pkg::DIST_W);
    end else if (run) begin
      rad  <= rad << 2;
      rem  <= fit ? (rem_sh - trial) : rem_sh;
      root <= {root[dmat_pkg::DIST_W-2:0], fit};
      cnt  <= cnt - dmat_pkg::RT_CNT_W'(1);
    end
  end

endmodule

// ----- rtl/core/pairwise_distance_matrix_top.sv -----
// Top level of the pairwise Euclidean distance matrix block.
//
//   channel  | handshake                      | payload
//   request  | start, busy (taken: start&!busy) | req    (dmat_pkg::req_t)
//   result   | result_valid, one-cycle strobe | result (dmat_pkg::rsp_t)
//   config   | APB psel/penable/pwrite, pready=1 | paddr, pwdata, prdata
//
// A load request leaves busy low.
// A row request holds busy until its last column result, at COORD_BITS 16
// (per column: one RAM read, 17 squarer steps, 25 root steps, two handoffs).
// An out-of-range row gives its error result in the cycle after the request.
// Synchronous reset clears control and sets point_count to 64; stores are not cleared.
// Results cannot be stalled; each strobe lasts one cycle.
`include "assert_macros.svh"

module pairwise_distance_matrix_top (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  dmat_pkg::req_t               req,
  output logic                         result_valid,
  output dmat_pkg::rsp_t               result,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [dmat_pkg::APB_AW-1:0]  paddr,
  input  logic [dmat_pkg::APB_DW-1:0]  pwdata,
  output logic [dmat_pkg::APB_DW-1:0]  prdata,
  output logic                         pready
);

  dmat_pkg::state_t state;
  dmat_pkg::state_t state_next;

  logic [dmat_pkg::PC_W-1:0]       point_count;
  logic [dmat_pkg::PC_W-1:0]       pc_clamp;
  logic [dmat_pkg::CNT_W-1:0]      n_act;
  logic [dmat_pkg::PT_AW-1:0]      col;
  logic                            col_last;
  logic [dmat_pkg::COORD_BITS-1:0] xi;
  logic [dmat_pkg::COORD_BITS-1:0] yi;
  logic [dmat_pkg::COORD_BITS-1:0] xj;
  logic [dmat_pkg::COORD_BITS-1:0] yj;

  logic accept;
  logic row_ok;
  logic row_go;
  logic col_adv;
  logic cfg_wr;

  logic                         ram_we;
  logic [dmat_pkg::PT_W-1:0]    ram_wdata;
  logic [dmat_pkg::PT_AW-1:0]   raddr;
  logic [dmat_pkg::PT_W-1:0]    rdata;

  logic                           sq_load;
  logic [dmat_pkg::MAG_BITS-1:0]  dx;
  logic [dmat_pkg::MAG_BITS-1:0]  dy;
  logic [dmat_pkg::PROD_BITS-1:0] px;
  logic [dmat_pkg::PROD_BITS-1:0] py;
  logic                           sqx_done;
  logic                           sqy_done;
  logic [dmat_pkg::SQ_BITS-1:0]   sum;
  logic                           rt_load;
  logic                           rt_done;
  logic [dmat_pkg::DIST_W-1:0]    root;

  logic           res_valid_next;
  dmat_pkg::rsp_t res_next;

  function automatic logic [dmat_pkg::COORD_BITS-1:0] to_coord(
    input logic [dmat_pkg::IN_COORD_W-1:0] f
  );
    logic [dmat_pkg::IN_COORD_W+dmat_pkg::COORD_BITS-1:0] w;
    w = {dmat_pkg::COORD_BITS'(0), f};
    return w[dmat_pkg::COORD_BITS-1:0];
  endfunction

  function automatic logic [dmat_pkg::MAG_BITS-1:0] absdiff(
    input logic [dmat_pkg::COORD_BITS-1:0] a,
    input logic [dmat_pkg::COORD_BITS-1:0] b
  );
    logic signed [dmat_pkg::MAG_BITS-1:0] ea;
    logic signed [dmat_pkg::MAG_BITS-1:0] eb;
    logic signed [dmat_pkg::MAG_BITS-1:0] d;
    ea = dmat_pkg::MAG_BITS'($signed(a));
    eb = dmat_pkg::MAG_BITS'($signed(b));
    d  = ea - eb;
    return d[dmat_pkg::MAG_BITS-1] ? dmat_pkg::MAG_BITS'(-d) : dmat_pkg::MAG_BITS'(d);
  endfunction

  assign busy   = (state != dmat_pkg::ST_IDLE);
  assign accept = start && !busy;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr == dmat_pkg::REG_POINT_COUNT) ? dmat_pkg::APB_DW'(point_count) : '0;

  assign pc_clamp = (point_count > dmat_pkg::PC_W'(dmat_pkg::POINTS))
                  ? dmat_pkg::PC_W'(dmat_pkg::POINTS) : point_count;
  assign row_ok   = dmat_pkg::PC_W'(req.index) < pc_clamp;
  assign col_last = (dmat_pkg::CNT_W'(col) + dmat_pkg::CNT_W'(1)) == n_act;

  assign ram_we    = accept && (req.op == dmat_pkg::OP_LOAD)
                  && (dmat_pkg::PC_W'(req.index) < dmat_pkg::PC_W'(dmat_pkg::POINTS));
  assign ram_wdata = {to_coord(req.x_coord), to_coord(req.y_coord)};

  assign xj  = rdata[dmat_pkg::PT_W-1:dmat_pkg::COORD_BITS];
  assign yj  = rdata[dmat_pkg::COORD_BITS-1:0];
  assign dx  = absdiff(xi, xj);
  assign dy  = absdiff(yi, yj);
  assign sum = dmat_pkg::SQ_BITS'(px) + dmat_pkg::SQ_BITS'(py);

  dmat_ram #(
    .WIDTH (dmat_pkg::PT_W),
    .DEPTH (dmat_pkg::POINTS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (req.index[dmat_pkg::PT_AW-1:0]),
    .wdata (ram_wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  dmat_sq u_sq_x (
    .clk     (clk),
    .rst     (rst),
    .load    (sq_load),
    .operand (dx),
    .done    (sqx_done),
    .product (px)
  );

  dmat_sq u_sq_y (
    .clk     (clk),
    .rst     (rst),
    .load    (sq_load),
    .operand (dy),
    .done    (sqy_done),
    .product (py)
  );

  dmat_sqrt u_sqrt (
    .clk  (clk),
    .rst  (rst),
    .load (rt_load),
    .sum  (sum),
    .done (rt_done),
    .root (root)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dmat_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next         = state;
    sq_load            = 1'b0;
    rt_load            = 1'b0;
    row_go             = 1'b0;
    col_adv            = 1'b0;
    raddr              = col;
    res_valid_next     = 1'b0;
    res_next.distance  = root;
    res_next.column    = dmat_pkg::COL_W'(col);
    res_next.last      = col_last;
    res_next.row_error = 1'b0;
    case (state)
      dmat_pkg::ST_IDLE: begin
        raddr = req.index[dmat_pkg::PT_AW-1:0];
        if (accept && (req.op == dmat_pkg::OP_ROW)) begin
          if (row_ok) begin
            row_go     = 1'b1;
            state_next = dmat_pkg::ST_ROWRD;
          end else begin
            res_valid_next     = 1'b1;
            res_next.distance  = '0;
            res_next.column    = '0;
            res_next.last      = 1'b1;
            res_next.row_error = 1'b1;
          end
        end
      end
      dmat_pkg::ST_ROWRD: begin
        raddr      = col;
        state_next = dmat_pkg::ST_COLRD;
      end
      dmat_pkg::ST_COLRD: begin
        sq_load    = 1'b1;
        state_next = dmat_pkg::ST_SQ;
      end
      dmat_pkg::ST_SQ: begin
        if (sqx_done) begin
          rt_load    = 1'b1;
          state_next = dmat_pkg::ST_ROOT;
        end
      end
      dmat_pkg::ST_ROOT: begin
        raddr = dmat_pkg::PT_AW'(col + dmat_pkg::PT_AW'(1));
        if (rt_done) begin
          res_valid_next = 1'b1;
          if (col_last) begin
            state_next = dmat_pkg::ST_IDLE;
          end else begin
            col_adv    = 1'b1;
            state_next = dmat_pkg::ST_COLRD;
          end
        end
      end
      default: begin
        state_next = dmat_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      point_count  <= dmat_pkg::PC_RESET;
      col          <= '0;
      n_act        <= '0;
    end else begin
      result_valid <= res_valid_next;
      if (cfg_wr && (paddr == dmat_pkg::REG_POINT_COUNT)) begin
        point_count <= pwdata[dmat_pkg::PC_W-1:0];
      end
      if (row_go) begin
        col   <= '0;
        n_act <= dmat_pkg::CNT_W'(pc_clamp);
      end else if (col_adv) begin
        col <= dmat_pkg::PT_AW'(col + dmat_pkg::PT_AW'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid_next) begin
      result <= res_next;
    end
    if (state == dmat_pkg::ST_ROWRD) begin
      xi <= xj;
      yi <= yj;
    end
  end

  `ASSERT_NORST(a_rst_quiet, rst |=> !result_valid && !busy)
  `ASSERT_CLK(a_err_shape, result_valid && result.row_error |-> result.last && result.column == '0)
  `ASSERT_CLK(a_col_range, result_valid && !result.row_error |-> dmat_pkg::PC_W'(result.column) < dmat_pkg::PC_W'(n_act))
  `ASSERT_CLK(a_sq_lockstep, sqx_done |-> sqy_done && state == dmat_pkg::ST_SQ)
  `ASSERT_CLK(a_load_silent, accept && req.op == dmat_pkg::OP_LOAD |=> !busy && !result_valid)
  `ASSERT_CLK(a_last_idle, result_valid && result.last |-> !busy)

endmodule

// ----- tb/sv/pairwise_distance_matrix_top_tb.sv -----
// Self-checking testbench for the pairwise distance matrix block: point loads, row requests, APB setup.
`timescale 1ns / 100ps

module pairwise_distance_matrix_top_tb;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 60;
  localparam int IDLE_PERCENT   = 38;

  logic                        clk          = 1'b0;
  logic                        rst          = 1'b1;
  logic                        start        = 1'b0;
  logic                        busy;
  dmat_pkg::req_t              req          = '0;
  logic                        result_valid;
  dmat_pkg::rsp_t              result;
  logic                        psel         = 1'b0;
  logic                        penable      = 1'b0;
  logic                        pwrite       = 1'b0;
  logic [dmat_pkg::APB_AW-1:0] paddr        = '0;
  logic [dmat_pkg::APB_DW-1:0] pwdata       = '0;
  logic [dmat_pkg::APB_DW-1:0] prdata;
  logic                        pready;

  pairwise_distance_matrix_top dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .req          (req),
    .result_valid (result_valid),
    .result       (result),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #5 clk = ~clk;

  dmat_pkg::req_t                         pending_reqs[$];
  dmat_pkg::rsp_t                         dist_expect[$];
  logic signed [dmat_pkg::COORD_BITS-1:0] pt_x [dmat_pkg::POINTS];
  logic signed [dmat_pkg::COORD_BITS-1:0] pt_y [dmat_pkg::POINTS];
  logic [dmat_pkg::PC_W-1:0]              cur_count   = dmat_pkg::PC_RESET;
  logic [dmat_pkg::POINTS-1:0]            loaded      = '0;
  bit                                     taken       = 1'b0;
  bit                                     calm        = 1'b0;
  int                                     mismatches  = 0;
  int                                     idle_cycles = 0;

  task automatic report(string what, longint unsigned want, longint unsigned got);
    mismatches++;
    if (mismatches <= 10) $display("mismatch on %s: expected %0d, got %0d", what, want, got);
  endtask

  function automatic logic [dmat_pkg::DIST_W-1:0] q8_distance(int i, int j);
    longint          dx;
    longint          dy;
    longint unsigned sq;
    longint unsigned rad;
    longint unsigned root;
    longint unsigned trial;
    dx = pt_x[i];
    dx = dx - pt_x[j];
    dy = pt_y[i];
    dy = dy - pt_y[j];
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    sq = longint'(dx * dx) + longint'(dy * dy);
    if (sq >= (64'd1 << dmat_pkg::SAT_BIT)) return '1;
    rad = sq << 16;
    root = 0;
    for (int b = dmat_pkg::DIST_W - 1; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= rad) root = trial;
    end
    return root[dmat_pkg::DIST_W-1:0];
  endfunction

  function automatic void predict_distances(dmat_pkg::req_t r);
    int             n;
    dmat_pkg::rsp_t e;
    n = (cur_count > dmat_pkg::POINTS) ? dmat_pkg::POINTS : int'(cur_count);
    if (r.op == dmat_pkg::OP_LOAD) begin
      if (r.index < dmat_pkg::POINTS) begin
        pt_x[r.index] = r.x_coord[dmat_pkg::COORD_BITS-1:0];
        pt_y[r.index] = r.y_coord[dmat_pkg::COORD_BITS-1:0];
      end
    end else if (r.index >= n) begin
      e = '0;
      e.last = 1'b1;
      e.row_error = 1'b1;
      dist_expect = {dist_expect, e};
    end else begin
      for (int j = 0; j < n; j++) begin
        e.distance  = q8_distance(r.index, j);
        e.column    = j[dmat_pkg::COL_W-1:0];
        e.last      = (j == n - 1);
        e.row_error = 1'b0;
        dist_expect = {dist_expect, e};
      end
    end
  endfunction

  always @(negedge clk) begin : driver
    dmat_pkg::req_t noise;
    if (!rst && (taken || !start)) begin
      taken = 1'b0;
      if (pending_reqs.size() != 0 && (calm || $urandom_range(99) >= IDLE_PERCENT)) begin
        req   <= pending_reqs.pop_front();
        start <= 1'b1;
      end else begin
        noise.op      = 1'($urandom_range(1));
        noise.index   = dmat_pkg::IDX_W'($urandom_range(63));
        noise.x_coord = dmat_pkg::IN_COORD_W'($urandom_range(65535));
        noise.y_coord = dmat_pkg::IN_COORD_W'($urandom_range(65535));
        req   <= noise;
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : monitor
    dmat_pkg::rsp_t want;
    bit             active;
    if (!rst) begin
      active = 1'b0;
      if (result_valid) begin
        if (dist_expect.size() == 0) begin
          report("unexpected result", 0, result);
        end else begin
          active = 1'b1;
          want = dist_expect.pop_front();
          if (result.distance !== want.distance)
            report("distance", want.distance, result.distance);
          if (result.column !== want.column) report("column", want.column, result.column);
          if (result.last !== want.last) report("last", want.last, result.last);
          if (result.row_error !== want.row_error)
            report("row_error", want.row_error, result.row_error);
        end
      end
      if (start && !busy) begin
        active = 1'b1;
        predict_distances(req);
        taken = 1'b1;
      end
      if (psel && penable && pwrite && pready) begin
        active = 1'b1;
        if (paddr == dmat_pkg::REG_POINT_COUNT) cur_count = pwdata[dmat_pkg::PC_W-1:0];
      end
      idle_cycles = active ? 0 : idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  function automatic logic [dmat_pkg::IN_COORD_W-1:0] rand_coord();
    case ($urandom_range(9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return dmat_pkg::IN_COORD_W'($urandom_range(65535));
    endcase
  endfunction

  task automatic push_load(int slot, logic [dmat_pkg::IN_COORD_W-1:0] x,
                           logic [dmat_pkg::IN_COORD_W-1:0] y);
    dmat_pkg::req_t r;
    r.op      = dmat_pkg::OP_LOAD;
    r.index   = slot[dmat_pkg::IDX_W-1:0];
    r.x_coord = x;
    r.y_coord = y;
    pending_reqs = {pending_reqs, r};
    loaded[slot] = 1'b1;
  endtask

  task automatic push_row(int row);
    dmat_pkg::req_t r;
    r.op      = dmat_pkg::OP_ROW;
    r.index   = row[dmat_pkg::IDX_W-1:0];
    r.x_coord = rand_coord();
    r.y_coord = rand_coord();
    pending_reqs = {pending_reqs, r};
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || start || dist_expect.size() != 0 || busy) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_point_count(int value);
    logic [dmat_pkg::APB_DW-1:0] wdata;
    wdata = $urandom;
    wdata[dmat_pkg::PC_W-1:0] = value[dmat_pkg::PC_W-1:0];
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= dmat_pkg::REG_POINT_COUNT;
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== {{(dmat_pkg::APB_DW - dmat_pkg::PC_W){1'b0}}, cur_count})
      report("point_count readback", cur_count, prdata);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic run_phase(int pc, int count, bit quiet);
    int n;
    int r;
    set_point_count(pc);
    n = (pc > dmat_pkg::POINTS) ? dmat_pkg::POINTS : pc;
    calm = quiet;
    for (int s = 0; s < n; s++) if (!loaded[s]) push_load(s, rand_coord(), rand_coord());
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(99);
      if (r < 35) push_load($urandom_range(dmat_pkg::POINTS - 1), rand_coord(), rand_coord());
      else if (r < 45 && n < dmat_pkg::POINTS) push_row($urandom_range(dmat_pkg::POINTS - 1, n));
      else if (n > 0) push_row($urandom_range(n - 1));
      else push_row($urandom_range(dmat_pkg::POINTS - 1));
    end
    wait_drained();
    calm = 1'b0;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    set_point_count(4);
    push_load(0, 16'h8000, 16'h8000);
    push_load(1, 16'h7FFF, 16'h7FFF);
    push_load(2, 16'h0000, 16'h0000);
    push_load(3, 16'h7FFF, 16'h8000);
    push_row(0);
    push_row(1);
    push_row(3);
    push_row(4);
    push_row(63);
    push_load(63, 16'hFFFF, 16'h0001);
    push_load(2, 16'hFFFF, 16'hFFFF);
    push_row(2);
    push_row(1);
    wait_drained();
    set_point_count(1);
    push_row(0);
    push_row(1);
    wait_drained();
    set_point_count(0);
    push_row(0);
    push_row(63);
    wait_drained();

    run_phase(1, 40, 1'b0);
    run_phase(2, 50, 1'b0);
    run_phase(8, 60, 1'b0);
    run_phase(0, 20, 1'b0);
    run_phase(5, 60, 1'b1);
    run_phase(127, 12, 1'b0);
    run_phase(3, 60, 1'b0);
    run_phase(16, 40, 1'b0);
    run_phase(64, 10, 1'b0);
    run_phase(6, 60, 1'b0);

    repeat (100) @(posedge clk);
    if (dist_expect.size() != 0) report("results never delivered", 0, dist_expect.size());
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/dmat_pkg.sv
rtl/core/dmat_ram.sv
rtl/core/dmat_sq.sv
rtl/core/dmat_sqrt.sv
rtl/core/pairwise_distance_matrix_top.sv
tb/sv/pairwise_distance_matrix_top_tb.sv
